/* hw/rtl/adsr_pkg.sv */
// Shared types, constants and rate-table functions for the ADSR envelope generator.
// No dependencies; every other file in hw/rtl imports this package.
`default_nettype none

package adsr_pkg;

	localparam int unsigned LevelW = 15;
	localparam int unsigned CdW    = 22;
	localparam int unsigned RateW  = 7;

	localparam logic [LevelW-1:0] LEVEL_MAX = 15'h7FFF;
	localparam logic [LevelW-1:0] EXP_KNEE  = 15'h6000;
	localparam logic [RateW-1:0]  RATE_SLOW = 7'd48;
	localparam logic [RateW-1:0]  RATE_LOW  = 7'd40;
	localparam logic [RateW-1:0]  RATE_HIGH = 7'd44;

	// Register indexes on the configuration port
	localparam logic REG_AD = 1'b0;
	localparam logic REG_SR = 1'b1;

	typedef struct packed {
		logic [15:0] ad_word;
		logic [15:0] sr_word;
	} adsr_cfg_t;

	// Packed so that level sits in the lowest bits, as on the output stream
	typedef struct packed {
		logic [2:0]        phase;
		logic              done_res;
		logic [LevelW-1:0] level;
	} adsr_res_t;

	// Ticks between steps: 1 below the slow threshold, else a power of two
	function automatic logic [CdW-1:0] rate_ticks(input logic [RateW-1:0] r);
		logic [CdW-1:0] t;
		if (r < RATE_SLOW) begin
			t = CdW'(1);
		end else begin
			t = CdW'(1) << (r[6:2] - 5'd11);
		end
		return t;
	endfunction

	// Step magnitude: small base amount, shifted up for the faster rates
	function automatic logic [LevelW-1:0] rate_mag(input logic dec, input logic [RateW-1:0] r);
		logic [3:0]        m;
		logic [LevelW-1:0] v;
		m = dec ? (4'd8 - {2'b00, r[1:0]}) : (4'd7 - {2'b00, r[1:0]});
		v = {11'b0, m};
		if (r < RATE_SLOW) begin
			v = v << (4'd11 - r[5:2]);
		end
		return v;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/adsr_cfg_regs.sv */
// APB-style register file holding the two envelope setting words.
// Depends on adsr_pkg for the register indexes and the settings struct.
`default_nettype none

module adsr_cfg_regs
	import adsr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output adsr_cfg_t        cfg
);

	logic [15:0] ad_word_q;
	logic [15:0] sr_word_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ad_word_q <= '0;
			sr_word_q <= '0;
		end else if (wr_en) begin
			if (paddr[2] == REG_SR) begin
				sr_word_q <= pwdata[15:0];
			end else begin
				ad_word_q <= pwdata[15:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_SR) begin
			prdata = {16'b0, sr_word_q};
		end else begin
			prdata = {16'b0, ad_word_q};
		end
	end

	assign cfg.ad_word = ad_word_q;
	assign cfg.sr_word = sr_word_q;

endmodule

`default_nettype wire

/* hw/rtl/adsr_core.sv */
// Envelope state and the combinational step logic for one tick.
// Depends on adsr_pkg for constants, rate functions and the result struct.
`default_nettype none

module adsr_core
	import adsr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire logic      key_off,
	input  wire logic      restart,
	input  wire adsr_cfg_t cfg,
	output adsr_res_t      res
);

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	phase_t            phase_q;
	logic [LevelW-1:0] level_q;
	logic [CdW-1:0]    cd_q;
	logic [RateW-1:0]  rate_q;
	logic              fall_q;
	logic              expo_q;
	logic [LevelW-1:0] tgt_q;
	logic              fin_q;

	phase_t            ent_phase;
	logic              ent_fall;
	logic [RateW-1:0]  ent_rate;
	logic              ent_expo;
	logic [LevelW-1:0] ent_tgt;
	logic [CdW-1:0]    ent_cd;
	logic              entered;
	logic              fin_now;
	logic [LevelW-1:0] decay_tgt;

	logic [LevelW-1:0]   mag;
	logic [CdW-1:0]      reload;
	logic [2*LevelW-1:0] prod;
	logic [2*LevelW:0]   prod_rnd;
	logic [LevelW:0]     step_amt;
	logic [LevelW:0]     rise_sum;
	logic [CdW-1:0]      step_cd;
	logic [LevelW-1:0]   step_level;

	// Decay target: (sustain level + 1) * 0x800, saturated
	assign decay_tgt = (cfg.ad_word[3:0] == 4'hF) ? LEVEL_MAX
		: {cfg.ad_word[3:0] + 4'd1, 11'b0};

	// Phase transitions, in priority order
	always_comb begin
		ent_phase = phase_q;
		ent_fall  = fall_q;
		ent_rate  = rate_q;
		ent_expo  = expo_q;
		ent_tgt   = tgt_q;
		ent_cd    = cd_q;
		entered   = 1'b0;
		fin_now   = 1'b0;
		if (phase_q == PH_IDLE) begin
			ent_phase = PH_ATTACK;
			ent_fall  = 1'b0;
			ent_rate  = cfg.ad_word[14:8];
			ent_expo  = cfg.ad_word[15];
			ent_tgt   = LEVEL_MAX;
			entered   = 1'b1;
		end else if (phase_q == PH_ATTACK && level_q >= tgt_q) begin
			ent_phase = PH_DECAY;
			ent_fall  = 1'b1;
			ent_rate  = {1'b0, cfg.ad_word[7:4], 2'b00};
			ent_expo  = 1'b1;
			ent_tgt   = decay_tgt;
			entered   = 1'b1;
		end else if (phase_q == PH_DECAY && level_q <= tgt_q) begin
			ent_phase = PH_SUSTAIN;
			ent_fall  = cfg.sr_word[14];
			ent_rate  = cfg.sr_word[12:6];
			ent_expo  = cfg.sr_word[15];
			ent_tgt   = '0;
			entered   = 1'b1;
		end else if (key_off && phase_q != PH_RELEASE) begin
			ent_phase = PH_RELEASE;
			ent_fall  = 1'b1;
			ent_rate  = {cfg.sr_word[4:0], 2'b00};
			ent_expo  = cfg.sr_word[5];
			ent_tgt   = '0;
			entered   = 1'b1;
		end else if (phase_q == PH_RELEASE && level_q <= tgt_q) begin
			fin_now = 1'b1;
		end
		if (entered) begin
			ent_cd = rate_ticks(ent_rate);
		end
	end

	// One step of the level, or a countdown tick
	assign mag      = rate_mag(ent_fall, ent_rate);
	assign reload   = rate_ticks(ent_rate);
	assign prod     = {{LevelW{1'b0}}, mag} * {{LevelW{1'b0}}, level_q};
	assign prod_rnd = {1'b0, prod} + {{(LevelW+1){1'b0}}, LEVEL_MAX};
	assign rise_sum = {1'b0, level_q} + step_amt;

	always_comb begin
		step_amt   = {1'b0, mag};
		step_cd    = reload;
		step_level = level_q;
		if (ent_cd > CdW'(1)) begin
			step_cd = ent_cd - CdW'(1);
		end else begin
			if (ent_expo) begin
				if (ent_fall) begin
					// round the falling amount up: floor of the negative step
					step_amt = prod_rnd[2*LevelW:LevelW];
				end else if (level_q >= EXP_KNEE) begin
					if (ent_rate < RATE_LOW) begin
						step_amt = {1'b0, mag} >> 2;
					end else if (ent_rate >= RATE_HIGH) begin
						step_cd = reload >> 2;
					end else begin
						step_amt = {1'b0, mag} >> 1;
						step_cd  = reload >> 1;
					end
				end
			end
			if (ent_fall) begin
				step_level = (step_amt > {1'b0, level_q}) ? '0
					: LevelW'({1'b0, level_q} - step_amt);
			end else begin
				step_level = (rise_sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX
					: rise_sum[LevelW-1:0];
			end
		end
	end

	always_comb begin
		if (restart) begin
			res = '{phase: PH_IDLE, done_res: 1'b0, level: '0};
		end else if (fin_q || fin_now) begin
			res = '{phase: PH_RELEASE, done_res: 1'b1, level: '0};
		end else begin
			res = '{phase: ent_phase, done_res: 1'b0, level: step_level};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			level_q <= '0;
			cd_q    <= '0;
			rate_q  <= '0;
			fall_q  <= 1'b0;
			expo_q  <= 1'b0;
			tgt_q   <= LEVEL_MAX;
			fin_q   <= 1'b0;
		end else if (fire) begin
			if (restart) begin
				phase_q <= PH_IDLE;
				level_q <= '0;
				cd_q    <= '0;
				rate_q  <= '0;
				fall_q  <= 1'b0;
				expo_q  <= 1'b0;
				tgt_q   <= LEVEL_MAX;
				fin_q   <= 1'b0;
			end else if (fin_q) begin
				fin_q <= 1'b1;
			end else if (fin_now) begin
				fin_q   <= 1'b1;
				level_q <= '0;
			end else begin
				phase_q <= ent_phase;
				fall_q  <= ent_fall;
				rate_q  <= ent_rate;
				expo_q  <= ent_expo;
				tgt_q   <= ent_tgt;
				cd_q    <= step_cd;
				level_q <= step_level;
			end
		end
	end

	a_fin_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> (level_q == '0 && phase_q == PH_RELEASE))
		else $error("finished envelope not silent in release");

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && restart) |=> (phase_q == PH_IDLE && level_q == '0 && !fin_q))
		else $error("restart did not clear the envelope");

	a_idle_to_attack: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !restart && phase_q == PH_IDLE) |=> (phase_q == PH_ATTACK))
		else $error("idle tick did not enter attack");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> ($stable(level_q) && $stable(phase_q) && $stable(fin_q)))
		else $error("envelope state moved without a tick");

endmodule

`default_nettype wire

/* hw/rtl/adsr_envelope_generator.sv */
// Top level of the ADSR envelope generator: stream registers around the step core.
// Depends on adsr_pkg, adsr_cfg_regs and adsr_core.
//
// Usage:
//   Each transfer on the slave stream is one envelope tick (one audio sample).
//   s_tdata carries key_off and restart; each accepted tick yields exactly one
//   result transfer on the master stream with level, done_res and phase.
//   Settings are written over the APB port while no tick is in flight; both
//   words are sampled only when the envelope enters a phase.
// Timing:
//   A tick is taken into the input register, stepped by combinational logic
//   (one 15x15 multiply on the exponential fall), and the result lands in
//   the output register, which drives m_tvalid. One tick per cycle is
//   sustained while the receiver keeps up.
// Stalls:
//   When m_tready is low the output register holds its result, the input
//   register holds the next tick, and s_tready drops once both are full.
// Reset:
//   arst_n clears the settings to zero, the envelope to idle at level 0 and
//   empties both stream registers.
`default_nettype none

module adsr_envelope_generator
	import adsr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave stream: [0] key_off, [1] restart, [7:2] zero
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,
	// master stream: [14:0] level, [15] done_res, [18:16] phase, [23:19] zero
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	adsr_cfg_t cfg;
	adsr_res_t res;

	logic      valid_s1;
	logic      key_off_s1;
	logic      restart_s1;
	logic      fire;
	logic      out_valid_q;
	adsr_res_t out_res_q;

	adsr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Step the held tick whenever the output register is free or draining
	assign fire     = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | fire;

	// Input register: take a new tick when empty or when the held one moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			key_off_s1 <= s_tdata[0];
			restart_s1 <= s_tdata[1];
		end
	end

	adsr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.key_off (key_off_s1),
		.restart (restart_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Output register: hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_res_q};

endmodule

`default_nettype wire

/* test/adsr_envelope_generator_tb.sv */
// Self-checking testbench for the ADSR envelope generator: directed phase walks, register
// access, output back-pressure and random envelopes against an in-bench envelope predictor.
// Depends on adsr_pkg and the adsr_envelope_generator top level.
`timescale 1ns / 100ps

module adsr_envelope_generator_tb;
	import adsr_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 300;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} env_phase_e;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// [0] key_off, [1] restart, [7:2] zero
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// [14:0] level, [15] done_res, [18:16] phase, [23:19] zero
	logic [23:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Settings as the envelope will sample them on the next phase entry
	logic [15:0] ad_word;
	logic [15:0] sr_word;

	// Predicted envelope state
	env_phase_e  env_phase;
	logic [14:0] env_level;
	logic [21:0] env_countdown;
	logic [6:0]  env_rate;
	logic        env_falling;
	logic        env_exp;
	logic [14:0] env_target;
	logic        env_finished;

	adsr_res_t   expected_env_q[$];
	adsr_res_t   got_env;
	adsr_res_t   want_env;

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned hold_req;
	int unsigned hold_left;
	int unsigned mismatches;
	int unsigned ticks_sent;
	int unsigned results_seen;
	int unsigned releases_done;
	int unsigned envelopes_run;
	int unsigned reg_writes;
	int unsigned tx_stall_cycles;
	int unsigned cycle_count;

	adsr_envelope_generator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------------------------------
	// Envelope predictor
	// ---------------------------------------------------------------------------------------

	// Ticks between steps: every tick for the fast rates, a power of two above them
	function automatic logic [21:0] reload_ticks(input logic [6:0] r);
		if (r < RATE_SLOW) begin
			return 22'd1;
		end
		return 22'(1) << ((int'(r) >> 2) - 11);
	endfunction

	// Signed step before any exponential scaling
	function automatic int step_size(input logic falling, input logic [6:0] r);
		int mag;
		mag = falling ? (8 - int'(r[1:0])) : (7 - int'(r[1:0]));
		if (r < RATE_SLOW) begin
			mag = mag << (11 - (int'(r) >> 2));
		end
		return falling ? -mag : mag;
	endfunction

	function automatic void clear_envelope();
		env_phase     = PH_IDLE;
		env_level     = '0;
		env_countdown = '0;
		env_rate      = '0;
		env_falling   = 1'b0;
		env_exp       = 1'b0;
		env_target    = LEVEL_MAX;
		env_finished  = 1'b0;
	endfunction

	function automatic void enter_phase(input env_phase_e ph, input logic falling,
			input logic [6:0] r, input logic expo, input logic [14:0] tgt);
		env_phase     = ph;
		env_falling   = falling;
		env_rate      = r;
		env_exp       = expo;
		env_target    = tgt;
		env_countdown = reload_ticks(r);
	endfunction

	// Advance the predicted envelope by one tick and return what the block should report
	function automatic adsr_res_t envelope_tick(input logic key_off, input logic restart);
		adsr_res_t   res;
		logic [14:0] tgt;
		int          stp;
		int          nl;
		longint      prod;
		res = '0;
		if (restart) begin
			clear_envelope();
			res.phase = PH_IDLE;
			return res;
		end
		if (env_finished) begin
			res.done_res = 1'b1;
			res.phase    = PH_RELEASE;
			return res;
		end

		// Phase transitions win over key_off on the same tick
		if (env_phase == PH_IDLE) begin
			enter_phase(PH_ATTACK, 1'b0, ad_word[14:8], ad_word[15], LEVEL_MAX);
		end else if (env_phase == PH_ATTACK && env_level >= env_target) begin
			tgt = (ad_word[3:0] == 4'hF) ? LEVEL_MAX : {ad_word[3:0] + 4'd1, 11'd0};
			enter_phase(PH_DECAY, 1'b1, {1'b0, ad_word[7:4], 2'b00}, 1'b1, tgt);
		end else if (env_phase == PH_DECAY && env_level <= env_target) begin
			enter_phase(PH_SUSTAIN, sr_word[14], sr_word[12:6], sr_word[15], 15'd0);
		end else if (key_off && env_phase != PH_RELEASE) begin
			enter_phase(PH_RELEASE, 1'b1, {sr_word[4:0], 2'b00}, sr_word[5], 15'd0);
		end else if (env_phase == PH_RELEASE && env_level <= env_target) begin
			env_finished = 1'b1;
			env_level    = '0;
			releases_done++;
			res.done_res = 1'b1;
			res.phase    = PH_RELEASE;
			return res;
		end

		if (env_countdown > 22'd1) begin
			env_countdown = env_countdown - 22'd1;
		end else begin
			stp           = step_size(env_falling, env_rate);
			env_countdown = reload_ticks(env_rate);
			if (env_exp) begin
				if (env_falling) begin
					// Scale by the level, rounding the fall away from zero
					prod = longint'(stp) * longint'(env_level);
					stp  = -int'((-prod + 64'sd32767) >>> 15);
				end else if (env_level >= EXP_KNEE) begin
					// Slow the rise above the knee
					if (env_rate < RATE_LOW) begin
						stp = stp >>> 2;
					end else if (env_rate >= RATE_HIGH) begin
						env_countdown = env_countdown >> 2;
					end else begin
						stp           = stp >>> 1;
						env_countdown = env_countdown >> 1;
					end
				end
			end
			nl = int'(env_level) + stp;
			if (nl < 0) begin
				nl = 0;
			end
			if (nl > int'(LEVEL_MAX)) begin
				nl = int'(LEVEL_MAX);
			end
			env_level = 15'(nl);
		end
		res.level = env_level;
		res.phase = env_phase;
		return res;
	endfunction

	// ---------------------------------------------------------------------------------------
	// Reporting, receiver and result checking
	// ---------------------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("MISMATCH at cycle %0d: %s got 0x%0h expected 0x%0h",
			cycle_count, what, got, want);
		mismatches++;
	endtask

	// Receiver: drop tready at random, or for a long stretch when a hold is requested
	initial begin
		m_tready  = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				m_tready  = 1'b0;
				hold_left = hold_left - 1;
			end else begin
				m_tready = ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Compare each result transfer with the oldest predicted tick, field by field
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_env = adsr_res_t'(m_tdata[18:0]);
			results_seen++;
			if (expected_env_q.size() == 0) begin
				report_mismatch("unexpected result, tdata", 32'(m_tdata), 0);
			end else begin
				want_env = expected_env_q.pop_front();
				if (got_env.level != want_env.level) begin
					report_mismatch("level", 32'(got_env.level), 32'(want_env.level));
				end
				if (got_env.done_res != want_env.done_res) begin
					report_mismatch("done_res", 32'(got_env.done_res),
						32'(want_env.done_res));
				end
				if (got_env.phase != want_env.phase) begin
					report_mismatch("phase", 32'(got_env.phase), 32'(want_env.phase));
				end
			end
		end
	end

	// Watchdog: end the run if it overstays the cycle budget
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding",
			cycle_count, expected_env_q.size());
		$display("Test completed with failures");
		$finish;
	end

	// ---------------------------------------------------------------------------------------
	// Drivers; every task starts and ends just after a falling edge
	// ---------------------------------------------------------------------------------------

	// Offer one tick, hold it until the transfer, then predict its result
	task automatic send_tick(input logic key_off, input logic restart);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {6'b0, restart, key_off};
		do begin
			@(posedge clk);
			if (!s_tready) begin
				tx_stall_cycles++;
			end
		end while (!s_tready);
		expected_env_q.insert(expected_env_q.size(), envelope_tick(key_off, restart));
		ticks_sent++;
		@(negedge clk);
	endtask

	// Stop offering ticks and wait for every result to drain, plus the pipeline depth
	task automatic settle();
		s_tvalid = 1'b0;
		while (expected_env_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [15:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {reg_sel, 2'b00};
		pwdata  = {16'b0, value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		if (reg_sel == REG_AD) begin
			ad_word = value;
		end else begin
			sr_word = value;
		end
		reg_writes++;
	endtask

	task automatic apb_check_read(input logic reg_sel, input logic [15:0] want);
		logic [31:0] rd;
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = {reg_sel, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		if (rd != {16'b0, want}) begin
			report_mismatch(reg_sel == REG_AD ? "attack/decay readback"
				: "sustain/release readback", rd, {16'b0, want});
		end
	endtask

	task automatic write_settings(input logic [15:0] ad, input logic [15:0] sr);
		settle();
		apb_write(REG_AD, ad);
		apb_write(REG_SR, sr);
	endtask

	// ---------------------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------------------

	task automatic test_register_access();
		apb_write(REG_AD, 16'hA5C3);
		apb_write(REG_SR, 16'h5A3C);
		apb_check_read(REG_AD, 16'hA5C3);
		apb_check_read(REG_SR, 16'h5A3C);
		apb_write(REG_AD, 16'hFFFF);
		apb_write(REG_SR, 16'hFFFF);
		apb_check_read(REG_AD, 16'hFFFF);
		apb_check_read(REG_SR, 16'hFFFF);
		apb_write(REG_AD, 16'h0000);
		apb_write(REG_SR, 16'h0000);
		apb_check_read(REG_AD, 16'h0000);
		apb_check_read(REG_SR, 16'h0000);
	endtask

	// Walk one envelope through every phase: fast linear attack, decay to a sustain level
	// above the knee, exponential sustain rise with a zero reload count, release to silence
	task automatic test_phase_sequence();
		// Sustain level 12, decay rate 4, attack rate 0 linear
		// Sustain rate 44 rising exponential, release rate 0 linear
		write_settings(16'h004C, 16'h8B00);
		envelopes_run++;
		send_tick(1'b1, 1'b1);              // restart and key_off together
		repeat (3) send_tick(1'b0, 1'b0);   // attack up to full scale
		send_tick(1'b1, 1'b0);              // key_off on the attack-to-decay tick
		repeat (9) send_tick(1'b0, 1'b0);   // decay, then sustain above the knee
		repeat (5) send_tick(1'b1, 1'b0);   // release, reach zero, hold finished
		send_tick(1'b0, 1'b1);              // restart out of the finished state
		send_tick(1'b1, 1'b0);              // key_off from idle still enters attack
	endtask

	// All settings at their top values: slowest rates, every mode bit set
	task automatic test_extreme_settings();
		write_settings(16'hFFFF, 16'hFFFF);
		envelopes_run++;
		repeat (3) send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
	endtask

	// Hold the receiver off for a long stretch while ticks keep coming, so the block
	// fills both registers and stalls its input
	task automatic test_backpressure();
		int unsigned saved_tx;
		saved_tx    = tx_idle_pct;
		tx_idle_pct = 0;
		write_settings(16'h0035, 16'h4180);
		envelopes_run++;
		send_tick(1'b0, 1'b1);
		hold_req = HOLD_CYCLES;
		repeat (40) send_tick($urandom_range(7) == 0, 1'b0);
		settle();
		tx_idle_pct = saved_tx;
	endtask

	// Random settings, mostly fast enough for each envelope to reach sustain and release
	task automatic test_random_envelopes(input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		int unsigned koff_at;
		int unsigned i;
		logic [6:0]  atk_rate;
		logic [6:0]  sus_rate;
		logic [3:0]  dec_rate;
		logic [4:0]  rel_rate;
		logic [15:0] ad;
		logic [15:0] sr;
		logic        key;
		sent = 0;
		while (sent < n_items) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: atk_rate = 7'($urandom_range(23));
				6:                atk_rate = 7'($urandom_range(47, 24));
				7:                atk_rate = ($urandom_range(1) != 0) ? 7'd127 : 7'd0;
				default:          atk_rate = 7'($urandom_range(127));
			endcase
			case ($urandom_range(7))
				0, 1, 2: sus_rate = 7'($urandom_range(23));
				3, 4:    sus_rate = 7'($urandom_range(47, 36));
				5:       sus_rate = 7'($urandom_range(63, 48));
				default: sus_rate = 7'($urandom_range(127));
			endcase
			dec_rate = ($urandom_range(5) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(5));
			rel_rate = ($urandom_range(5) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(5));
			ad = {1'($urandom_range(1)), atk_rate, dec_rate, 4'($urandom_range(15))};
			sr = {1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
				sus_rate, 1'($urandom_range(1)), rel_rate};
			if ($urandom_range(7) == 0) begin
				ad = 16'($urandom_range(16'hFFFF));
			end
			if ($urandom_range(7) == 0) begin
				sr = 16'($urandom_range(16'hFFFF));
			end
			// Now and then carry on from where the last envelope left off
			if ($urandom_range(5) != 0) begin
				write_settings(ad, sr);
			end
			envelopes_run++;
			if ($urandom_range(9) != 0) begin
				send_tick(1'($urandom_range(1)), 1'b1);
				sent++;
			end
			len     = $urandom_range(70, 20);
			koff_at = $urandom_range(len - 1, len / 3);
			for (i = 0; i < len; i++) begin
				if (i >= koff_at) begin
					key = ($urandom_range(9) != 0);
				end else begin
					key = ($urandom_range(24) == 0);
				end
				send_tick(key, $urandom_range(59) == 0);
			end
			sent += len;
		end
	endtask

	// ---------------------------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------------------------

	initial begin
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		tx_idle_pct     = 6;
		rx_idle_pct     = 85;
		hold_req        = 0;
		mismatches      = 0;
		ticks_sent      = 0;
		results_seen    = 0;
		releases_done   = 0;
		envelopes_run   = 0;
		reg_writes      = 0;
		tx_stall_cycles = 0;
		ad_word         = '0;
		sr_word         = '0;
		clear_envelope();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Busy sender, sparse receiver
		test_register_access();
		test_phase_sequence();
		test_extreme_settings();
		test_random_envelopes(250);
		test_backpressure();

		// Sparse sender, busy receiver
		tx_idle_pct = 85;
		rx_idle_pct = 6;
		test_random_envelopes(250);

		// Back to back
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_envelopes(240);

		settle();
		repeat (8) @(negedge clk);

		$display("Ran %0d ticks over %0d envelopes (%0d releases reached silence), %0d results",
			ticks_sent, envelopes_run, releases_done, results_seen);
		$display("Made %0d register writes; input stalled %0d cycles; %0d cycles in all",
			reg_writes, tx_stall_cycles, cycle_count);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
